// ----- rtl/crrq_pkg.sv -----
// Package for the categorized round-robin queue.
// Holds opcodes, status codes and default sizes; no dependencies.
`default_nettype none
package crrq_pkg;
  localparam int NumCategoriesDef = 8;
  localparam int QueueDepthDef = 16;

  localparam logic [2:0] OP_SUBMIT  = 3'd0;
  localparam logic [2:0] OP_DEQUEUE = 3'd1;
  localparam logic [2:0] OP_CLEAR   = 3'd2;
  localparam logic [2:0] OP_CANCEL  = 3'd3;
  localparam logic [2:0] OP_DEPTH   = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_STOPPED    = 3'd1;
  localparam logic [2:0] ST_NULL       = 3'd2;
  localparam logic [2:0] ST_TABLE_FULL = 3'd3;
  localparam logic [2:0] ST_QUEUE_FULL = 3'd4;
  localparam logic [2:0] ST_EMPTY      = 3'd5;
endpackage
`default_nettype wire

// ----- rtl/crrq_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module crrq_ram #(
  parameter int Width = 16,
  parameter int Depth = 128
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/categorized_round_robin_queue_top.sv -----
// Top level of the categorized round-robin queue.
// Depends on crrq_pkg and crrq_ram.
//
// Usage: one transaction on the in_ channel carries an opcode, a category key
// and a task handle; each produces exactly one transaction on the out_ channel
// with a status, a dequeued handle and a count. cfg_we writes the stopped bit
// at any clock edge; the user is to change it only while the block is idle,
// and the block does not enforce this. One category slot or one queue is
// visited per cycle. A submit scans the slot table and then writes the task;
// a dequeue scans the rotation and then reads the task store; cancel and
// depth query sum the fill of every queue. Clear all, unused opcodes and
// requests refused at once go straight to the result.
// The block takes one transaction at a time: in_ready is high only while no
// transaction is in progress and the result register is free or being taken
// in the same cycle, so the next transaction can be accepted at the earliest
// in the same cycle as the result appears.
// A result waits in the output register while out_ready is low, and no new
// transaction is accepted until it has been taken.
// Reset clears the slot table, the queue counters, the active count and the
// stopped bit; the key, rotation and task stores need no clearing pass.
`default_nettype none
module categorized_round_robin_queue_top #(
  parameter int NUM_CATEGORIES = crrq_pkg::NumCategoriesDef,
  parameter int QUEUE_DEPTH    = crrq_pkg::QueueDepthDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_we,
  input  wire logic               cfg_wdata,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         in_op,
  input  wire logic signed [63:0] in_category,
  input  wire logic [15:0]        in_task_id,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_status,
  output logic [15:0]             out_task_out,
  output logic [15:0]             out_count
);
  localparam int SW = $clog2(NUM_CATEGORIES);
  localparam int CW = $clog2(NUM_CATEGORIES + 1);
  localparam int QW = $clog2(QUEUE_DEPTH);
  localparam int FW = $clog2(QUEUE_DEPTH + 1);
  localparam int PW = FW + 1;
  localparam int AW = SW + QW;
  localparam int TD = NUM_CATEGORIES * (1 << QW);
  localparam int SUMW = FW + CW + 1;
  localparam int CNTW = ((SUMW > 16) ? SUMW : 16) + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_MATCH, S_SUB_WR, S_DQ_SCAN, S_DQ_RD, S_SUM, S_OUT
  } state_t;

  state_t state_r;
  logic stopped_r;
  logic [CW-1:0] used_r;
  logic [FW-1:0] fill_r [NUM_CATEGORIES];
  logic [QW-1:0] head_r [NUM_CATEGORIES];
  logic [63:0] keys_r [NUM_CATEGORIES];
  logic [SW-1:0] rot_r [NUM_CATEGORIES];
  logic [15:0] active_r;
  logic [2:0] op_r;
  logic [63:0] key_r;
  logic [15:0] tid_r;
  logic [CW-1:0] idx_r;
  logic [SW-1:0] slot_r;
  logic [SUMW-1:0] sum_r;
  logic out_valid_r;
  logic [2:0] status_r;
  logic [15:0] task_r;
  logic [15:0] count_r;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [15:0] ram_rdata;
  logic out_free;
  logic [PW-1:0] wpos_sum;
  logic [QW-1:0] wpos;
  logic [QW-1:0] head_next;
  logic [SW-1:0] cur_slot;
  logic [SW-1:0] rot_head;

  crrq_ram #(.Width(16), .Depth(TD)) u_store (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(tid_r),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE) && out_free;
  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_task_out = task_r;
  assign out_count = count_r;

  assign cur_slot = idx_r[SW-1:0];
  assign rot_head = rot_r[0];

  always_comb begin
    wpos_sum = PW'(head_r[slot_r]) + PW'(fill_r[slot_r]);
    wpos = (wpos_sum >= PW'(QUEUE_DEPTH)) ? QW'(wpos_sum - PW'(QUEUE_DEPTH)) : QW'(wpos_sum);
    head_next = (head_r[slot_r] == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r[slot_r] + 1'b1;
    ram_we = (state_r == S_SUB_WR) && (fill_r[slot_r] < FW'(QUEUE_DEPTH));
    ram_waddr = {slot_r, wpos};
    if (state_r == S_DQ_SCAN) begin
      ram_raddr = {rot_head, head_r[rot_head]};
    end else begin
      ram_raddr = {slot_r, head_r[slot_r]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      stopped_r <= 1'b0;
      used_r <= '0;
      active_r <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CATEGORIES; i++) begin
        fill_r[i] <= '0;
        head_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        stopped_r <= cfg_wdata;
      end
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid && in_ready) begin
            op_r <= in_op;
            key_r <= in_category;
            tid_r <= in_task_id;
            idx_r <= '0;
            sum_r <= '0;
            status_r <= crrq_pkg::ST_OK;
            task_r <= '0;
            count_r <= '0;
            case (in_op)
              crrq_pkg::OP_SUBMIT: begin
                if (stopped_r) begin
                  status_r <= crrq_pkg::ST_STOPPED;
                  state_r <= S_OUT;
                end else if (in_task_id == '0) begin
                  status_r <= crrq_pkg::ST_NULL;
                  state_r <= S_OUT;
                end else begin
                  state_r <= S_MATCH;
                end
              end
              crrq_pkg::OP_DEQUEUE: begin
                if (stopped_r) begin
                  status_r <= crrq_pkg::ST_STOPPED;
                  state_r <= S_OUT;
                end else begin
                  state_r <= S_DQ_SCAN;
                end
              end
              crrq_pkg::OP_CLEAR: begin
                used_r <= '0;
                for (int i = 0; i < NUM_CATEGORIES; i++) begin
                  fill_r[i] <= '0;
                  head_r[i] <= '0;
                end
                state_r <= S_OUT;
              end
              crrq_pkg::OP_CANCEL, crrq_pkg::OP_DEPTH: begin
                state_r <= S_SUM;
              end
              default: begin
                state_r <= S_OUT;
              end
            endcase
          end
        end
        S_MATCH: begin
          if (idx_r == used_r) begin
            if (used_r == CW'(NUM_CATEGORIES)) begin
              status_r <= crrq_pkg::ST_TABLE_FULL;
              state_r <= S_OUT;
            end else begin
              keys_r[cur_slot] <= key_r;
              rot_r[cur_slot] <= cur_slot;
              head_r[cur_slot] <= '0;
              fill_r[cur_slot] <= '0;
              used_r <= used_r + 1'b1;
              slot_r <= cur_slot;
              state_r <= S_SUB_WR;
            end
          end else if (keys_r[cur_slot] == key_r) begin
            slot_r <= cur_slot;
            state_r <= S_SUB_WR;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_SUB_WR: begin
          if (fill_r[slot_r] < FW'(QUEUE_DEPTH)) begin
            fill_r[slot_r] <= fill_r[slot_r] + 1'b1;
          end else begin
            status_r <= crrq_pkg::ST_QUEUE_FULL;
          end
          state_r <= S_OUT;
        end
        S_DQ_SCAN: begin
          if (idx_r == used_r) begin
            status_r <= crrq_pkg::ST_EMPTY;
            state_r <= S_OUT;
          end else begin
            for (int i = 0; i < NUM_CATEGORIES - 1; i++) begin
              if (CW'(i + 1) < used_r) begin
                rot_r[i] <= rot_r[i + 1];
              end
            end
            rot_r[SW'(used_r - 1'b1)] <= rot_head;
            if (fill_r[rot_head] != '0) begin
              slot_r <= rot_head;
              state_r <= S_DQ_RD;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        S_DQ_RD: begin
          task_r <= ram_rdata;
          head_r[slot_r] <= head_next;
          fill_r[slot_r] <= fill_r[slot_r] - 1'b1;
          if (active_r != 16'hFFFF) begin
            active_r <= active_r + 1'b1;
          end
          state_r <= S_OUT;
        end
        S_SUM: begin
          if (idx_r == CW'(NUM_CATEGORIES)) begin
            if (op_r == crrq_pkg::OP_CANCEL) begin
              count_r <= ((CNTW'(sum_r) + CNTW'(active_r)) > CNTW'(16'hFFFF)) ? 16'hFFFF
                         : 16'(CNTW'(sum_r) + CNTW'(active_r));
              for (int i = 0; i < NUM_CATEGORIES; i++) begin
                fill_r[i] <= '0;
                head_r[i] <= '0;
              end
            end else begin
              count_r <= (CNTW'(sum_r) > CNTW'(16'hFFFF)) ? 16'hFFFF : 16'(sum_r);
            end
            state_r <= S_OUT;
          end else begin
            sum_r <= sum_r + SUMW'(fill_r[cur_slot]);
            idx_r <= idx_r + 1'b1;
          end
        end
        S_OUT: begin
          if (out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> state_r == S_IDLE)
    else $error("ready outside idle");
  a_used_max: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= CW'(NUM_CATEGORIES))
    else $error("slot count overflow");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped");
  a_dq_task: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DQ_RD |=> status_r == crrq_pkg::ST_OK)
    else $error("dequeue status");
endmodule
`default_nettype wire
